// File: hw/rtl/gss_token_header_parser_unit_assert.svh
// Assertion macros for the token header parser.
`ifndef GSS_TOKEN_HEADER_PARSER_UNIT_ASSERT_SVH
`define GSS_TOKEN_HEADER_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define GTP_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("token header parser: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define GTP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("token header parser: next-cycle check failed");
`else
`define GTP_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define GTP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// File: hw/rtl/gtp_pkg.sv
// Types and constants of the token header parser.
package gtp_pkg;

  // Limits of the length fields and of the compared OID.
  localparam int unsigned MaxLenBytes = 4;
  localparam int unsigned MaxOidBytes = 16;
  localparam int unsigned ExpOidBytes = 16;

  // Tag values of the token framing.
  localparam logic [7:0] OuterTagByte = 8'h60;
  localparam logic [7:0] OidTagByte   = 8'h06;

  // Parser phase.
  typedef enum logic [3:0] {
    PhTag,
    PhOuterLen1,
    PhOuterLenMore,
    PhOidTag,
    PhOidLen1,
    PhOidLenMore,
    PhOidBytes,
    PhPayload,
    PhErr
  } phase_e;

  // Token status reported on the final byte.
  typedef enum logic [2:0] {
    StOk,
    StBadOuterTag,
    StBadOuterLen,
    StLenMismatch,
    StBadOidTag,
    StBadOidLen,
    StOidDiffers
  } status_e;

  // Label of each passed-through byte.
  typedef enum logic [1:0] {
    KindHeader,
    KindOid,
    KindPayload,
    KindDiscard
  } byte_kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegCheckOid,
    RegExpOidLen,
    RegExpOidLow,
    RegExpOidHigh
  } cfg_reg_e;

endpackage

// File: hw/rtl/gtp_if.sv
// Stream interfaces carrying token bytes in and labeled bytes out.
interface gtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface gtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] byte_kind;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output byte_out, output byte_kind, output done_res,
                  output status, input ready);
  modport sink (input valid, input byte_out, input byte_kind, input done_res,
                input status, output ready);
endinterface

// File: hw/rtl/gss_token_header_parser_unit.sv
// An accepted word is written into the result register at the edge that accepts it.
// Throughput: one word per cycle while the result register is free or drains; the parser state and the result
// register update together. A new word is taken whenever the result register is empty or is being drained.
// Reset (rst_ni low, asynchronous) returns the parser to expect an outer tag,
// empties the result register and loads the configuration reset values.
`include "gss_token_header_parser_unit_assert.svh"

module gss_token_header_parser_unit
  import gtp_pkg::*;
#(
  parameter int unsigned MAX_LEN_BYTES = MaxLenBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gtp_in_if.sink       in_if,
  gtp_out_if.source    out_if,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_wdata_i
);

  localparam int unsigned LenCntW = $clog2(MAX_LEN_BYTES + 1);

  // Configuration registers.
  logic        check_oid_q;
  logic [4:0]  exp_len_q;
  logic [63:0] exp_low_q;
  logic [63:0] exp_high_q;

  // Parser state.
  phase_e               phase_q, phase_d;
  logic [LenCntW-1:0]   len_left_q, len_left_d;
  logic [31:0]          len_acc_q, len_acc_d;
  logic [31:0]          outer_rem_q, outer_rem_d;
  logic [31:0]          oid_rem_q, oid_rem_d;
  logic [4:0]           oid_idx_q, oid_idx_d;
  logic                 oid_mism_q, oid_mism_d;
  status_e              err_q, err_d;

  // Result register.
  logic        out_valid_q;
  logic [7:0]  byte_out_q;
  byte_kind_e  kind_q, kind_d;
  logic        done_q;
  status_e     status_q, status_d;

  logic        in_accept;
  logic [7:0]  b;
  logic        outer_known;
  logic        lf_long;
  logic [6:0]  lf_cnt;
  logic        lf_bad;
  logic        lm_over;
  logic [31:0] lm_acc;
  logic [LenCntW-1:0] lm_left;
  logic        oid_len_done;
  logic [31:0] oid_len_val;
  logic        oid_finish;
  logic [127:0] exp_oid;
  logic [7:0]  exp_byte;

  // Handshake: take a word when the result register is free or drains now.
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_oid_q <= 1'b1;
      exp_len_q   <= '0;
      exp_low_q   <= '0;
      exp_high_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegCheckOid:   check_oid_q <= cfg_wdata_i[0];
        RegExpOidLen:  exp_len_q   <= cfg_wdata_i[4:0];
        RegExpOidLow:  exp_low_q   <= cfg_wdata_i;
        RegExpOidHigh: exp_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Length field helpers shared by the outer and the OID length.
  assign lf_long = b[7];
  assign lf_cnt  = b[6:0];
  assign lf_bad  = (lf_cnt == 7'd0) || (lf_cnt > 7'(MAX_LEN_BYTES));
  assign lm_over = len_acc_q > 32'h00FF_FFFF;
  assign lm_acc  = {len_acc_q[23:0], b};
  assign lm_left = (len_left_q != '0) ? len_left_q - LenCntW'(1) : len_left_q;

  // Expected OID byte at the current index.
  assign exp_oid  = {exp_high_q, exp_low_q};
  assign exp_byte = exp_oid[oid_idx_q[3:0]*8 +: 8];

  // Next parser state and the result for the incoming word.
  always_comb begin
    phase_d      = phase_q;
    len_left_d   = len_left_q;
    len_acc_d    = len_acc_q;
    outer_rem_d  = outer_rem_q;
    oid_rem_d    = oid_rem_q;
    oid_idx_d    = oid_idx_q;
    oid_mism_d   = oid_mism_q;
    err_d        = err_q;
    kind_d       = KindHeader;
    status_d     = StOk;
    oid_len_done = 1'b0;
    oid_len_val  = '0;
    oid_finish   = 1'b0;

    outer_known = (phase_q >= PhOidTag && phase_q <= PhPayload) ||
                  (phase_q == PhErr && err_q >= StLenMismatch);

    // Every byte after the outer length counts against it.
    if (outer_known) begin
      if (outer_rem_q == '0) begin
        if (err_q == StOk || err_q >= StBadOidTag) begin
          err_d = StLenMismatch;
        end
        phase_d = PhErr;
      end else begin
        outer_rem_d = outer_rem_q - 32'd1;
      end
    end

    case (phase_d)
      PhTag: begin
        if (b != OuterTagByte) begin
          if (err_d == StOk) err_d = StBadOuterTag;
          phase_d = PhErr;
        end else begin
          phase_d = PhOuterLen1;
        end
      end
      PhOuterLen1: begin
        if (!lf_long) begin
          outer_rem_d = {25'd0, lf_cnt};
          phase_d     = PhOidTag;
        end else if (lf_bad) begin
          if (err_d == StOk) err_d = StBadOuterLen;
          phase_d = PhErr;
        end else begin
          len_left_d = LenCntW'(lf_cnt);
          len_acc_d  = '0;
          phase_d    = PhOuterLenMore;
        end
      end
      PhOuterLenMore: begin
        if (lm_over) begin
          if (err_d == StOk) err_d = StBadOuterLen;
          phase_d = PhErr;
        end else begin
          len_acc_d  = lm_acc;
          len_left_d = lm_left;
          if (lm_left == '0) begin
            outer_rem_d = lm_acc;
            phase_d     = PhOidTag;
          end
        end
      end
      PhOidTag: begin
        if (b != OidTagByte) begin
          if (err_d == StOk) err_d = StBadOidTag;
          phase_d = PhErr;
        end else begin
          phase_d = PhOidLen1;
        end
      end
      PhOidLen1: begin
        if (!lf_long) begin
          oid_len_done = 1'b1;
          oid_len_val  = {25'd0, lf_cnt};
        end else if (lf_bad) begin
          if (err_d == StOk) err_d = StBadOidLen;
          phase_d = PhErr;
        end else begin
          len_left_d = LenCntW'(lf_cnt);
          len_acc_d  = '0;
          phase_d    = PhOidLenMore;
        end
      end
      PhOidLenMore: begin
        if (lm_over) begin
          if (err_d == StOk) err_d = StBadOidLen;
          phase_d = PhErr;
        end else begin
          len_acc_d  = lm_acc;
          len_left_d = lm_left;
          if (lm_left == '0) begin
            oid_len_done = 1'b1;
            oid_len_val  = lm_acc;
          end
        end
      end
      PhOidBytes: begin
        kind_d = KindOid;
        if (oid_idx_q >= exp_len_q || oid_idx_q >= 5'(MaxOidBytes) || exp_byte != b) begin
          oid_mism_d = 1'b1;
        end
        if (oid_idx_q < 5'd31) begin
          oid_idx_d = oid_idx_q + 5'd1;
        end
        if (oid_rem_q != '0) begin
          oid_rem_d = oid_rem_q - 32'd1;
        end
        if (oid_rem_d == '0) begin
          oid_finish = 1'b1;
        end
      end
      PhPayload: begin
        kind_d = KindPayload;
      end
      default: begin
        kind_d = KindDiscard;
      end
    endcase

    // A complete OID length must fit in the rest of the token.
    if (oid_len_done) begin
      if (oid_len_val > outer_rem_d) begin
        if (err_d == StOk) err_d = StBadOidLen;
        phase_d = PhErr;
      end else begin
        oid_rem_d  = oid_len_val;
        oid_idx_d  = '0;
        oid_mism_d = 1'b0;
        if (oid_len_val == '0) begin
          oid_finish = 1'b1;
        end else begin
          phase_d = PhOidBytes;
        end
      end
    end

    // End of the OID: compare its length and bytes when enabled.
    if (oid_finish) begin
      if (check_oid_q && (oid_mism_d || oid_idx_d != exp_len_q)) begin
        if (err_d == StOk) err_d = StOidDiffers;
        phase_d = PhErr;
      end else begin
        phase_d = PhPayload;
      end
    end

    // Final word: report the status and start over.
    if (in_if.last) begin
      if (err_d != StOk) begin
        status_d = err_d;
        if (err_d >= StBadOidTag && outer_rem_d != '0) begin
          status_d = StLenMismatch;
        end
      end else if (phase_d == PhTag || phase_d == PhOuterLen1 ||
                   phase_d == PhOuterLenMore) begin
        status_d = StBadOuterLen;
      end else if (outer_rem_d != '0) begin
        status_d = StLenMismatch;
      end else if (phase_d == PhOidTag) begin
        status_d = StBadOidTag;
      end else if (phase_d != PhPayload) begin
        status_d = StBadOidLen;
      end else begin
        status_d = StOk;
      end
      phase_d     = PhTag;
      len_left_d  = '0;
      len_acc_d   = '0;
      outer_rem_d = '0;
      oid_rem_d   = '0;
      oid_idx_d   = '0;
      oid_mism_d  = 1'b0;
      err_d       = StOk;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhTag;
      len_left_q  <= '0;
      len_acc_q   <= '0;
      outer_rem_q <= '0;
      oid_rem_q   <= '0;
      oid_idx_q   <= '0;
      oid_mism_q  <= 1'b0;
      err_q       <= StOk;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      len_acc_q   <= len_acc_d;
      outer_rem_q <= outer_rem_d;
      oid_rem_q   <= oid_rem_d;
      oid_idx_q   <= oid_idx_d;
      oid_mism_q  <= oid_mism_d;
      err_q       <= err_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_out_q <= b;
      kind_q     <= kind_d;
      done_q     <= in_if.last;
      status_q   <= status_d;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.byte_out  = byte_out_q;
  assign out_if.byte_kind = kind_q;
  assign out_if.done_res  = done_q;
  assign out_if.status    = status_q;

  // A status other than ok appears only on the final word.
  `GTP_ASSERT_IMPL(a_status_on_last, clk_i, rst_ni, out_valid_q && !done_q, status_q == StOk)
  // A recorded error always parks the parser in the error phase.
  `GTP_ASSERT_IMPL(a_err_phase, clk_i, rst_ni, err_q != StOk, phase_q == PhErr)
  // After a final word the parser is back at the start of a token.
  `GTP_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, in_accept && in_if.last,
                   phase_q == PhTag && err_q == StOk && outer_rem_q == '0)
  // Every accepted word fills the result register.
  `GTP_ASSERT_NEXT(a_result_filled, clk_i, rst_ni, in_accept, out_valid_q)

endmodule
